// ===== sv/bmr_pkg.sv =====
// Shared types, constants and state encodings for the Berlekamp-Massey recurrence unit.
package bmr_pkg;

  localparam int DATA_W = 30;
  localparam int POS_W = 5;
  localparam int ORD_W = 6;
  localparam int MAX_ORDER_DEF = 32;
  localparam int INDEX_BITS_DEF = 16;
  localparam logic [DATA_W-1:0] MOD_RESET = 30'd998244353;

  typedef struct packed {
    logic [DATA_W-1:0] term_value;
    logic first_term;
    logic last_term;
  } item_t;

  typedef struct packed {
    logic valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_MUL,
    MAC_RED
  } mac_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RED,
    B_DOT,
    B_DECIDE,
    B_INV,
    B_MULT,
    B_UPD,
    B_SWAP,
    B_COMMIT,
    B_EMIT
  } back_state_t;

endpackage

// ===== sv/bmr_term_if.sv =====
// Input channel: one sequence term per request.
interface bmr_term_if;
  logic valid;
  logic ready;
  logic [bmr_pkg::DATA_W-1:0] term_value;
  logic first_term;
  logic last_term;
  modport source(output valid, term_value, first_term, last_term, input ready);
  modport sink(input valid, term_value, first_term, last_term, output ready);
endinterface

// ===== sv/bmr_result_if.sv =====
// Output channel: one recurrence coefficient with its base term per request.
interface bmr_result_if;
  logic valid;
  logic ready;
  logic [bmr_pkg::DATA_W-1:0] coefficient;
  logic [bmr_pkg::DATA_W-1:0] base_term;
  logic [bmr_pkg::POS_W-1:0] position;
  logic [bmr_pkg::ORD_W-1:0] order;
  logic overflow;
  logic last_result;
  modport source(output valid, coefficient, base_term, position, order, overflow,
                 last_result, input ready);
  modport sink(input valid, coefficient, base_term, position, order, overflow,
               last_result, output ready);
endinterface

// ===== sv/bmr_cfg_if.sv =====
// Configuration write channel for the prime modulus.
interface bmr_cfg_if;
  logic valid;
  logic ready;
  logic [bmr_pkg::DATA_W-1:0] prime_modulus;
  modport source(output valid, prime_modulus, input ready);
  modport sink(input valid, prime_modulus, output ready);
endinterface

// ===== sv/bmr_front.sv =====
// Front end: accepts terms and holds them in a two-entry queue for the engine.
module bmr_front (
  input  logic clk,
  input  logic rst,
  bmr_term_if.sink term_in,
  output bmr_pkg::queue_head_t head,
  input  logic pop
);

  bmr_pkg::item_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic take;

  assign term_in.ready = (count != 2'd2);
  assign push = term_in.valid && term_in.ready;
  assign take = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr].term_value <= term_in.term_value;
        slots[wr_ptr].first_term <= term_in.first_term;
        slots[wr_ptr].last_term <= term_in.last_term;
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, take})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/bmr_mac.sv =====
// Modular multiply-accumulate: (acc + a*b) mod p, one multiply then a 2-bit/cycle reduction.
module bmr_mac (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [bmr_pkg::DATA_W-1:0] acc,
  input  logic [bmr_pkg::DATA_W-1:0] a,
  input  logic [bmr_pkg::DATA_W-1:0] b,
  input  logic [bmr_pkg::DATA_W-1:0] p,
  output logic done,
  output logic [bmr_pkg::DATA_W-1:0] res
);

  localparam int DW = bmr_pkg::DATA_W;
  localparam int XW = 2 * DW + 2;
  localparam int STEPS = XW / 2;
  localparam int CW = $clog2(STEPS);
  localparam logic [CW-1:0] LAST_STEP = CW'(STEPS - 1);

  bmr_pkg::mac_state_t state, state_next;
  logic [2*DW-1:0] prod;
  logic [DW-1:0] acc_r;
  logic [XW-1:0] x;
  logic [DW-1:0] r;
  logic [CW-1:0] cnt;
  logic [DW-1:0] r_next;
  logic [XW-1:0] x_next;

  // two restoring-division steps; remainder stays below p
  always_comb begin
    logic [DW:0] t1;
    logic [DW-1:0] rr;
    logic [XW-1:0] xs;
    rr = r;
    xs = x;
    for (int s = 0; s < 2; s++) begin
      t1 = {rr, xs[XW-1]};
      xs = {xs[XW-2:0], 1'b0};
      if (t1 >= {1'b0, p}) begin
        t1 = t1 - {1'b0, p};
      end
      rr = t1[DW-1:0];
    end
    r_next = rr;
    x_next = xs;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bmr_pkg::MAC_IDLE: if (start) state_next = bmr_pkg::MAC_MUL;
      bmr_pkg::MAC_MUL: state_next = bmr_pkg::MAC_RED;
      bmr_pkg::MAC_RED: if (cnt == LAST_STEP) state_next = bmr_pkg::MAC_IDLE;
      default: state_next = bmr_pkg::MAC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmr_pkg::MAC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        bmr_pkg::MAC_IDLE: begin
          if (start) begin
            prod <= a * b;
            acc_r <= acc;
          end
        end
        bmr_pkg::MAC_MUL: begin
          x <= XW'(prod) + XW'(acc_r);
          r <= '0;
          cnt <= '0;
        end
        bmr_pkg::MAC_RED: begin
          r <= r_next;
          x <= x_next;
          cnt <= cnt + CW'(1);
          if (cnt == LAST_STEP) done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign res = r;

endmodule

// ===== sv/bmr_back.sv =====
// Back end: Berlekamp-Massey update engine and result sequencer.
module bmr_back #(
  parameter int MAX_ORDER = bmr_pkg::MAX_ORDER_DEF,
  parameter int INDEX_BITS = bmr_pkg::INDEX_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [bmr_pkg::DATA_W-1:0] p,
  input  bmr_pkg::queue_head_t head,
  output logic pop,
  bmr_result_if.source result_out
);

  localparam int DW = bmr_pkg::DATA_W;
  localparam int IW = INDEX_BITS;
  localparam int LEN_W = $clog2(MAX_ORDER + 1);
  localparam int IDX_W = $clog2(MAX_ORDER);
  localparam int CNT_W = $clog2(MAX_ORDER + 2);
  localparam logic [IW:0] MAX_W = (IW + 1)'(MAX_ORDER);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ORDER);

  bmr_pkg::back_state_t state, state_next;

  logic [DW-1:0] cp [MAX_ORDER];
  logic [DW-1:0] pp [MAX_ORDER];
  logic [DW-1:0] hw [MAX_ORDER];
  logic [DW-1:0] bs [MAX_ORDER];
  logic [DW-1:0] saved [MAX_ORDER];

  logic [LEN_W-1:0] cur_len, prev_len, old_len, new_len;
  logic [DW-1:0] prev_delta;
  logic [IW-1:0] change_index, term_index, gap;
  logic change_seen, ovf, swap_r, last_r;
  logic [DW-1:0] t_r, val_r, mult, pw_r, pw_b, e_r;
  logic sq, mac_wait;
  logic [CNT_W-1:0] idx;

  logic mac_start, mac_done;
  logic [DW-1:0] mac_acc, mac_a, mac_b, mac_res;

  logic out_valid;
  logic [DW-1:0] o_coef, o_base;
  logic [bmr_pkg::POS_W-1:0] o_pos;
  logic [bmr_pkg::ORD_W-1:0] o_ord;
  logic o_ovf, o_last;

  logic [CNT_W-1:0] rev, sv_idx;
  logic [IW+1:0] pos;
  logic [DW-1:0] pp_val, diff, tdiff;
  logic [IW-1:0] gap_c;
  logic [IW:0] need1, need2;
  logic [LEN_W-1:0] need2_sat, nl;
  logic swap_c, mismatch, full_upd;
  logic dot_go, upd_go, swap_go, out_load, emit_last;

  bmr_mac u_mac (
    .clk(clk), .rst(rst), .start(mac_start), .acc(mac_acc), .a(mac_a), .b(mac_b),
    .p(p), .done(mac_done), .res(mac_res)
  );

  assign rev = CNT_W'(prev_len) - idx;
  assign sv_idx = CNT_W'(old_len) - idx - CNT_W'(1);
  assign pos = (IW + 2)'(gap) + (IW + 2)'(idx) - (IW + 2)'(1);
  // the leading entry of the previous polynomial is the implicit -1
  assign pp_val = (idx == '0) ? p - DW'(1) : pp[rev[IDX_W-1:0]];
  assign diff = (val_r >= t_r) ? val_r - t_r : val_r + (p - t_r);
  assign tdiff = (t_r >= val_r) ? t_r - val_r : t_r + (p - val_r);

  assign gap_c = term_index - change_index;
  assign need1 = (IW + 1)'(term_index) + (IW + 1)'(1);
  assign need2 = (IW + 1)'(prev_len) + (IW + 1)'(gap_c);
  assign need2_sat = (need2 > MAX_W) ? MAX_LEN : need2[LEN_W-1:0];
  assign nl = (cur_len > need2_sat) ? cur_len : need2_sat;
  assign swap_c = ((IW + 1)'(prev_len) + (IW + 1)'(term_index)) >
                  ((IW + 1)'(cur_len) + (IW + 1)'(change_index));
  assign mismatch = (val_r != t_r);
  assign full_upd = mismatch && change_seen && (term_index > change_index);

  assign dot_go = (idx < CNT_W'(cur_len));
  assign upd_go = (idx <= CNT_W'(prev_len)) && (pos < (IW + 2)'(new_len));
  assign swap_go = (idx < CNT_W'(old_len));
  assign out_load = !out_valid || result_out.ready;
  assign emit_last = (cur_len == '0) || (CNT_W'(cur_len) == idx + CNT_W'(1));

  assign result_out.valid = out_valid;
  assign result_out.coefficient = o_coef;
  assign result_out.base_term = o_base;
  assign result_out.position = o_pos;
  assign result_out.order = o_ord;
  assign result_out.overflow = o_ovf;
  assign result_out.last_result = o_last;

  always_comb begin
    state_next = state;
    pop = 1'b0;
    mac_start = 1'b0;
    mac_acc = '0;
    mac_a = '0;
    mac_b = '0;
    unique case (state)
      bmr_pkg::B_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          state_next = bmr_pkg::B_RED;
        end
      end
      bmr_pkg::B_RED: begin
        mac_a = t_r;
        mac_b = DW'(1);
        mac_start = !mac_wait;
        if (mac_done) state_next = bmr_pkg::B_DOT;
      end
      bmr_pkg::B_DOT: begin
        mac_acc = val_r;
        mac_a = cp[idx[IDX_W-1:0]];
        mac_b = hw[idx[IDX_W-1:0]];
        mac_start = !mac_wait && dot_go;
        if (!mac_wait && !dot_go) state_next = bmr_pkg::B_DECIDE;
      end
      bmr_pkg::B_DECIDE: begin
        state_next = full_upd ? bmr_pkg::B_INV : bmr_pkg::B_COMMIT;
      end
      bmr_pkg::B_INV: begin
        mac_a = sq ? pw_b : pw_r;
        mac_b = pw_b;
        mac_start = !mac_wait && (e_r != '0) && (sq || e_r[0]);
        if (!mac_wait && (e_r == '0)) state_next = bmr_pkg::B_MULT;
      end
      bmr_pkg::B_MULT: begin
        mac_a = diff;
        mac_b = pw_r;
        mac_start = !mac_wait;
        if (mac_done) state_next = bmr_pkg::B_UPD;
      end
      bmr_pkg::B_UPD: begin
        mac_acc = cp[pos[IDX_W-1:0]];
        mac_a = pp_val;
        mac_b = mult;
        mac_start = !mac_wait && upd_go;
        if (!mac_wait && !upd_go) begin
          state_next = swap_r ? bmr_pkg::B_SWAP : bmr_pkg::B_COMMIT;
        end
      end
      bmr_pkg::B_SWAP: begin
        if (!swap_go) state_next = bmr_pkg::B_COMMIT;
      end
      bmr_pkg::B_COMMIT: begin
        state_next = last_r ? bmr_pkg::B_EMIT : bmr_pkg::B_IDLE;
      end
      bmr_pkg::B_EMIT: begin
        if (out_load && emit_last) state_next = bmr_pkg::B_IDLE;
      end
      default: state_next = bmr_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmr_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len <= '0;
      prev_len <= '0;
      prev_delta <= '0;
      change_index <= '0;
      change_seen <= 1'b0;
      term_index <= '0;
      ovf <= 1'b0;
      mac_wait <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < MAX_ORDER; k++) hw[k] <= '0;
    end else begin
      if (mac_start) begin
        mac_wait <= 1'b1;
      end else if (mac_done) begin
        mac_wait <= 1'b0;
      end
      if ((state == bmr_pkg::B_EMIT) && out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result_out.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        bmr_pkg::B_IDLE: begin
          if (head.valid) begin
            t_r <= head.item.term_value;
            last_r <= head.item.last_term;
            if (head.item.first_term) begin
              cur_len <= '0;
              prev_len <= '0;
              prev_delta <= '0;
              change_index <= '0;
              change_seen <= 1'b0;
              term_index <= '0;
              ovf <= 1'b0;
              for (int k = 0; k < MAX_ORDER; k++) hw[k] <= '0;
            end
          end
        end
        bmr_pkg::B_RED: begin
          if (mac_done) begin
            t_r <= mac_res;
            val_r <= '0;
            idx <= '0;
          end
        end
        bmr_pkg::B_DOT: begin
          if (mac_done) begin
            val_r <= mac_res;
            idx <= idx + CNT_W'(1);
          end
        end
        bmr_pkg::B_DECIDE: begin
          if (mismatch) begin
            if (!change_seen) begin
              change_seen <= 1'b1;
              change_index <= term_index;
              if (need1 > MAX_W) begin
                ovf <= 1'b1;
                cur_len <= MAX_LEN;
              end else begin
                cur_len <= need1[LEN_W-1:0];
              end
              for (int k = 0; k < MAX_ORDER; k++) cp[k] <= '0;
              prev_delta <= t_r;
            end else if (term_index <= change_index) begin
              ovf <= 1'b1;
            end else begin
              gap <= gap_c;
              swap_r <= swap_c;
              old_len <= cur_len;
              new_len <= nl;
              if (need2 > MAX_W) ovf <= 1'b1;
              for (int k = 0; k < MAX_ORDER; k++) begin
                saved[k] <= cp[k];
                if ((k >= int'(cur_len)) && (k < int'(nl))) cp[k] <= '0;
              end
              pw_r <= DW'(1);
              pw_b <= prev_delta;
              e_r <= p - DW'(2);
              sq <= 1'b0;
            end
          end
        end
        bmr_pkg::B_INV: begin
          // square-and-multiply over the exponent bits, low bit first
          if (!mac_wait && (e_r != '0) && !sq && !e_r[0]) sq <= 1'b1;
          if (mac_done) begin
            if (!sq) begin
              pw_r <= mac_res;
              sq <= 1'b1;
            end else begin
              pw_b <= mac_res;
              sq <= 1'b0;
              e_r <= e_r >> 1;
            end
          end
        end
        bmr_pkg::B_MULT: begin
          if (mac_done) begin
            mult <= mac_res;
            idx <= '0;
          end
        end
        bmr_pkg::B_UPD: begin
          if (mac_done) begin
            cp[pos[IDX_W-1:0]] <= mac_res;
            idx <= idx + CNT_W'(1);
          end else if (!mac_wait && !upd_go) begin
            cur_len <= new_len;
            idx <= '0;
          end
        end
        bmr_pkg::B_SWAP: begin
          if (swap_go) begin
            pp[idx[IDX_W-1:0]] <= saved[sv_idx[IDX_W-1:0]];
            idx <= idx + CNT_W'(1);
          end else begin
            prev_len <= old_len;
            change_index <= term_index;
            prev_delta <= tdiff;
          end
        end
        bmr_pkg::B_COMMIT: begin
          if ((IW + 1)'(term_index) < MAX_W) bs[term_index[IDX_W-1:0]] <= t_r;
          for (int k = MAX_ORDER - 1; k > 0; k--) hw[k] <= hw[k-1];
          hw[0] <= t_r;
          if (term_index != '1) begin
            term_index <= term_index + IW'(1);
          end else begin
            ovf <= 1'b1;
          end
          idx <= '0;
        end
        bmr_pkg::B_EMIT: begin
          if (out_load) begin
            o_coef <= (cur_len == '0) ? '0 : cp[idx[IDX_W-1:0]];
            o_base <= (cur_len == '0) ? '0 : bs[idx[IDX_W-1:0]];
            o_pos <= bmr_pkg::POS_W'(idx);
            o_ord <= bmr_pkg::ORD_W'(cur_len);
            o_ovf <= ovf;
            o_last <= emit_last;
            idx <= idx + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/berlekamp_massey_recurrence_unit.sv =====
// Top level of the Berlekamp-Massey recurrence unit over a prime field.
// Usage:
//   term_in   : one sequence term per request; first_term restarts the run,
//               last_term makes the unit report the recurrence found so far.
//   result_out: after a last term, one request per coefficient c[k] with base
//               term a[k], position k, order L, overflow and last_result on
//               the final one. An all-zero sequence gives a single order-0 result.
//   cfg       : writes the prime modulus; always ready, write only when idle.
// Datapath: every modular multiply-add goes through one shared multiplier
//   plus a 2-bit-per-cycle reduction. A term takes a reduction plus a dot
//   product over the L current coefficients, and more when it triggers
//   a polynomial update (Fermat inverse, then the scaled add over the previous
//   polynomial of length L'), plus a reversed copy of the polynomial when
//   the length grows.
// A two-entry queue takes terms while the engine works. After a last term the
//   results leave one per cycle through an output register; a stalled
//   receiver holds the engine and, once the queue fills, term_in.
// Reset: modulus returns to 998244353, run state is cleared, no results pend.
module berlekamp_massey_recurrence_unit #(
  parameter int MAX_ORDER = bmr_pkg::MAX_ORDER_DEF,
  parameter int INDEX_BITS = bmr_pkg::INDEX_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  bmr_term_if.sink term_in,
  bmr_result_if.source result_out,
  bmr_cfg_if.sink cfg
);

  logic [bmr_pkg::DATA_W-1:0] modulus;
  logic [bmr_pkg::DATA_W-1:0] p_eff;
  bmr_pkg::queue_head_t head;
  logic pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= bmr_pkg::MOD_RESET;
    end else if (cfg.valid) begin
      modulus <= cfg.prime_modulus;
    end
  end

  // moduli below two behave as two
  assign p_eff = (modulus < bmr_pkg::DATA_W'(2)) ? bmr_pkg::DATA_W'(2) : modulus;

  bmr_front u_front (
    .clk(clk), .rst(rst), .term_in(term_in), .head(head), .pop(pop)
  );

  bmr_back #(
    .MAX_ORDER(MAX_ORDER),
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .p(p_eff), .head(head), .pop(pop), .result_out(result_out)
  );

endmodule
